### rtl/mtcu_pkg.sv
package mtcu_pkg;

    // Operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP      = 8'd1;

    // Configuration reset values
    localparam logic [31:0] TICK_THRESHOLD_RST = 32'd5000;
    localparam logic [31:0] TIME_STEP_RST      = 32'd50;

    // Maximum access size in bytes
    localparam logic [3:0] MAX_BYTES = 4'd8;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [3:0]  access_bytes;
        logic [63:0] write_data;
        logic [31:0] interval;
    } t_in_item;

    typedef struct packed {
        logic [63:0] read_data;
        logic [63:0] current_time;
        logic        timer_irq;
    } t_out_item;

endpackage

### rtl/mtcu_lanes.sv
module mtcu_lanes
    import mtcu_pkg::*;
#(
    parameter int TIME_OFFSET    = 49144,
    parameter int COMPARE_OFFSET = 16384
) (
    input  logic        i_rd_en,
    input  logic        i_wr_en,
    input  logic [15:0] i_address,
    input  logic [3:0]  i_access_bytes,
    input  logic [63:0] i_write_data,
    input  logic [63:0] i_time,
    input  logic [63:0] i_compare,
    output logic [63:0] o_read_data,
    output logic [63:0] o_time_next,
    output logic [63:0] o_compare_next
);

    localparam logic [16:0] T_LO = 17'(TIME_OFFSET);
    localparam logic [16:0] T_HI = 17'(TIME_OFFSET + 8);
    localparam logic [16:0] C_LO = 17'(COMPARE_OFFSET);
    localparam logic [16:0] C_HI = 17'(COMPARE_OFFSET + 8);

    logic [3:0] n_bytes;

    // Saturate oversize accesses to eight bytes
    assign n_bytes = (i_access_bytes > MAX_BYTES) ? MAX_BYTES : i_access_bytes;

    // Gather read bytes; the time register wins where both cover a byte
    always_comb begin
        o_read_data = '0;
        for (int i = 0; i < 8; i++) begin
            logic [16:0] a;
            logic [16:0] dt;
            logic [16:0] dc;
            logic        hit_t;
            logic        hit_c;
            a     = {1'b0, i_address} + 17'(i);
            dt    = a - T_LO;
            dc    = a - C_LO;
            hit_t = (a >= T_LO) && (a < T_HI);
            hit_c = (a >= C_LO) && (a < C_HI);
            if (i_rd_en && (4'(i) < n_bytes)) begin
                if (hit_t) begin
                    o_read_data[i*8 +: 8] = i_time[{dt[2:0], 3'b000} +: 8];
                end else if (hit_c) begin
                    o_read_data[i*8 +: 8] = i_compare[{dc[2:0], 3'b000} +: 8];
                end
            end
        end
    end

    // Merge write bytes into each register lane
    always_comb begin
        o_time_next    = i_time;
        o_compare_next = i_compare;
        for (int j = 0; j < 8; j++) begin
            logic [17:0] dt;
            logic [17:0] dc;
            logic        own_c;
            dt    = {1'b0, T_LO} + 18'(j) - {2'b00, i_address};
            dc    = {1'b0, C_LO} + 18'(j) - {2'b00, i_address};
            own_c = !((COMPARE_OFFSET + j >= TIME_OFFSET) &&
                      (COMPARE_OFFSET + j < TIME_OFFSET + 8));
            if (i_wr_en && (dt < {14'd0, n_bytes})) begin
                o_time_next[j*8 +: 8] = i_write_data[{dt[2:0], 3'b000} +: 8];
            end
            if (i_wr_en && own_c && (dc < {14'd0, n_bytes})) begin
                o_compare_next[j*8 +: 8] = i_write_data[{dc[2:0], 3'b000} +: 8];
            end
        end
    end

endmodule

### rtl/mtcu_tick.sv
module mtcu_tick
    import mtcu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_tick_en,
    input  logic [31:0]          i_interval,
    output logic [31:0]          o_step
);

    logic [31:0] r_threshold;
    logic [31:0] r_step;
    logic [32:0] r_acc;
    logic [32:0] n_acc;
    logic [32:0] sum;
    logic        crossed;

    // Accumulate and test against the threshold
    assign sum     = r_acc + {1'b0, i_interval};
    assign crossed = sum >= {1'b0, r_threshold};
    assign n_acc   = crossed ? '0 : sum;

    // Drive the time advance for this tick
    assign o_step = (i_tick_en && crossed) ? r_step : '0;

    // Hold configuration and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= TICK_THRESHOLD_RST;
            r_step      <= TIME_STEP_RST;
            r_acc       <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == CFG_TICK_THRESHOLD)) begin
                r_threshold <= i_cfg_data;
            end
            if (i_cfg_valid && (i_cfg_index == CFG_TIME_STEP)) begin
                r_step <= i_cfg_data;
            end
            if (i_tick_en) begin
                r_acc <= n_acc;
            end
        end
    end

endmodule

### rtl/machine_timer_compare_unit.sv
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while results are taken; a result passes
// through the input register, then the result register with state update.
// Synchronous active-low reset clears time, compare and accumulator and sets both
// configuration registers (threshold 5000, step 50). A stalled result holds
// the state, so the input register fills and then backpressures the input.
// Configuration writes are taken in any cycle.
module machine_timer_compare_unit
    import mtcu_pkg::*;
#(
    parameter int TIME_OFFSET    = 49144,
    parameter int COMPARE_OFFSET = 16384
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    logic [63:0] r_rdata;
    logic [63:0] r_time;
    logic [63:0] r_cmp;

    logic        advance;
    logic        is_read;
    logic        is_write;
    logic        is_tick;
    logic [63:0] rdata;
    logic [63:0] time_wr;
    logic [63:0] cmp_wr;
    logic [31:0] step;

    // Move the held transaction into the result register when it is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign is_read  = r_in.operation == OP_READ;
    assign is_write = r_in.operation == OP_WRITE;
    assign is_tick  = r_in.operation == OP_TICK;

    mtcu_lanes #(
        .TIME_OFFSET   (TIME_OFFSET),
        .COMPARE_OFFSET(COMPARE_OFFSET)
    ) u_lanes (
        .i_rd_en       (is_read),
        .i_wr_en       (is_write),
        .i_address     (r_in.address),
        .i_access_bytes(r_in.access_bytes),
        .i_write_data  (r_in.write_data),
        .i_time        (r_time),
        .i_compare     (r_cmp),
        .o_read_data   (rdata),
        .o_time_next   (time_wr),
        .o_compare_next(cmp_wr)
    );

    mtcu_tick u_tick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_tick_en  (advance && is_tick),
        .i_interval (r_in.interval),
        .o_step     (step)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // Result register and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_time      <= '0;
            r_cmp       <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && is_write) begin
                r_time <= time_wr;
                r_cmp  <= cmp_wr;
            end else if (advance && is_tick) begin
                r_time <= r_time + {32'd0, step};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rdata <= rdata;
        end
    end

    // State changes only when a result loads, so it matches the held result
    assign o_out_valid             = r_out_valid;
    assign o_out_item.read_data    = r_rdata;
    assign o_out_item.current_time = r_time;
    assign o_out_item.timer_irq    = r_time >= r_cmp;

endmodule
